// File: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// request payloads, stored entry type, cell control and status codes
// ----------------------------------------------------------------------------
package spq_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_EMIT   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] age;
    logic [3:0] priority_req;
  } spq_in_t;

  typedef struct packed {
    logic [7:0] out_age;
    logic [3:0] out_priority;
    logic [3:0] position;
    logic [1:0] status;
    logic       last;
  } spq_out_t;

  typedef struct packed {
    logic [7:0] age;
    logic [3:0] prio;
  } spq_entry_t;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic       insert;
    logic       rotate;
    spq_entry_t new_entry;
  } spq_ctl_t;

  typedef enum logic {
    SPQ_IDLE,
    SPQ_DUMP
  } spq_state_t;

endpackage

// File: src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// holds one entry, shifts it to the right on insert, left on dump rotation
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  spq_ctl_t        ctl,
  input  logic [CW-1:0]   count,
  input  logic            left_lt,
  input  spq_entry_t      left_entry,
  input  spq_entry_t      right_entry,
  input  spq_entry_t      head_entry,
  output logic            lt,
  output logic            ins_here,
  output spq_entry_t      entry
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;
  logic       occ;
  logic       at_end;
  logic       at_tail;

  assign occ     = CW'(IDX) < count;
  assign at_end  = CW'(IDX) == count;
  assign at_tail = CW'(IDX + 1) == count;
  // stored priority strictly below the new one
  assign lt       = occ && (entry_r.prio < ctl.new_entry.prio);
  assign ins_here = !left_lt && (lt || at_end);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (left_lt) begin
        entry_nxt = left_entry;
      end else if (lt || at_end) begin
        entry_nxt = ctl.new_entry;
      end
    end else if (ctl.rotate) begin
      // head wraps round to the last occupied slot
      if (at_tail) begin
        entry_nxt = head_entry;
      end else begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in descending order
// chain of cells, insert shifts in place, dump rotates entries past the head
// ----------------------------------------------------------------------------
//  port group  dir  handshake              payload
//  in_*        in   in_valid / in_ready    spq_in_t  (operation, age, priority_req)
//  out_*       out  out_valid / out_ready  spq_out_t (age, priority, position,
//                                                     status, last)
//
//  insert: all cells compare and shift together, one result
//  dump: accept, then one entry per cycle from the head cell while the output
//    takes them, count entries in all; an empty dump gives one EMPTY result
//  a single output register separates the result side; a result waiting
//    there with out_ready low holds the chain and blocks new requests
//  rst_n is synchronous; it clears the count, the dump index, the state and
//    out_valid only, the slot contents stay as they are until written
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_out_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int PW = (IW > 4) ? IW : 4;

  // control state
  spq_state_t    state_r;
  spq_state_t    state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  spq_out_t      out_data_r;
  spq_out_t      out_data_nxt;

  // chain wiring
  spq_ctl_t   ctl;
  spq_entry_t cell_entry [QUEUE_DEPTH];
  logic       cell_lt    [QUEUE_DEPTH];
  logic       ins_here   [QUEUE_DEPTH];
  logic [IW-1:0] ins_pos;
  logic [PW-1:0] ins_pos_w;
  logic [PW-1:0] idx_w;

  logic load_out;
  logic in_fire;
  logic is_insert;
  logic is_full;
  logic dump_start;
  logic emit;
  logic dump_last;

  assign load_out   = !out_valid_r || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign is_full    = count_r == CW'(QUEUE_DEPTH);
  assign is_insert  = in_fire && (in_data.operation == OP_INSERT);
  assign dump_start = in_fire && (in_data.operation == OP_DUMP) && (count_r != '0);
  assign emit       = (state_r == SPQ_DUMP) && load_out;
  assign dump_last  = emit && (CW'(idx_r) + CW'(1) == count_r);

  assign ctl.insert        = is_insert && !is_full;
  assign ctl.rotate        = emit;
  assign ctl.new_entry.age  = in_data.age;
  assign ctl.new_entry.prio = in_data.priority_req;

  // the row of cells, slot 0 is the head of the queue
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .left_lt     ((g == 0) ? 1'b0 : cell_lt[(g == 0) ? 0 : g - 1]),
      .left_entry  (cell_entry[(g == 0) ? 0 : g - 1]),
      .right_entry (cell_entry[(g == QUEUE_DEPTH - 1) ? 0 : g + 1]),
      .head_entry  (cell_entry[0]),
      .lt          (cell_lt[g]),
      .ins_here    (ins_here[g]),
      .entry       (cell_entry[g])
    );
  end

  // exactly one cell flags the insert point when the queue is not full
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ins_here[i]) begin
        ins_pos = ins_pos | IW'(i);
      end
    end
  end

  assign ins_pos_w = PW'(ins_pos);
  assign idx_w     = PW'(idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SPQ_IDLE: begin
        if (dump_start) begin
          state_nxt = SPQ_DUMP;
        end
      end
      SPQ_DUMP: begin
        if (dump_last) begin
          state_nxt = SPQ_IDLE;
        end
      end
      default: state_nxt = SPQ_IDLE;
    endcase
  end

  // outputs and datapath registers
  always_comb begin
    in_ready      = (state_r == SPQ_IDLE) && load_out;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ctl.insert) begin
      count_nxt = count_r + CW'(1);
    end

    if (dump_start) begin
      idx_nxt = '0;
    end else if (emit) begin
      idx_nxt = idx_r + IW'(1);
    end

    priority if (in_fire && is_insert) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_age      = '0;
      out_data_nxt.out_priority = '0;
      out_data_nxt.last         = 1'b1;
      if (is_full) begin
        out_data_nxt.position = '0;
        out_data_nxt.status   = ST_FULL;
      end else begin
        out_data_nxt.position = ins_pos_w[3:0];
        out_data_nxt.status   = ST_ACCEPT;
      end
    end else if (in_fire && !dump_start) begin
      // dump on an empty queue
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_age      = '0;
      out_data_nxt.out_priority = '0;
      out_data_nxt.position     = '0;
      out_data_nxt.status       = ST_EMPTY;
      out_data_nxt.last         = 1'b1;
    end else if (emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_age      = cell_entry[0].age;
      out_data_nxt.out_priority = cell_entry[0].prio;
      out_data_nxt.position     = idx_w[3:0];
      out_data_nxt.status       = ST_EMIT;
      out_data_nxt.last         = dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SPQ_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
